// ===== hdl/pfbd_pkg.sv =====
// pfbd_pkg: screen geometry, command descriptor, font rom and helpers for the
// paged framebuffer drawer. No dependencies; all but the ram and ifs use it.
`default_nettype none

package pfbd_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int FB_BYTES      = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
	localparam int PAGES         = (SCREEN_HEIGHT + 7) / 8;
	localparam int ADDR_W        = $clog2(FB_BYTES);
	localparam int IDX_W         = $clog2(PAGES * SCREEN_WIDTH);
	localparam int PG_W          = $clog2(PAGES + 1);
	localparam int FIRST_CODE    = 32;
	localparam int LAST_CODE     = 90;
	localparam int GLYPHS        = LAST_CODE - FIRST_CODE + 1;
	localparam int GLYPH_COLS    = 5;
	localparam int GLYPH_ROWS    = 7;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_CHAR  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	localparam logic [GLYPH_ROWS-1:0] SPAN_PIXEL  = 7'h01;
	localparam logic [GLYPH_ROWS-1:0] SPAN_GLYPH  = 7'h7F;
	localparam logic [3:0]            STEPS_PIXEL = 4'd1;
	localparam logic [3:0]            STEPS_GLYPH = 4'd9;

	typedef enum logic [1:0] {
		OP_DRAW,
		OP_WIPE,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DRAW,
		ST_DRAIN,
		ST_WIPE,
		ST_READ,
		ST_RWAIT,
		ST_RESULT
	} st_t;

	typedef struct packed {
		op_t                                      op;
		logic signed [9:0]                        x;
		logic signed [9:0]                        y;
		logic [GLYPH_ROWS-1:0]                    span;
		logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0]    cols;
		logic [3:0]                               last_step;
		logic                                     rd_ok;
		logic [ADDR_W-1:0]                        rd_addr;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t entry;
	} q_wr_t;

	typedef struct packed {
		logic valid;
		cmd_t entry;
	} q_rd_t;

	// column 0 in the top byte
	localparam logic [39:0] FONT_ROM [GLYPHS] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543
	};

	function automatic logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_cols(logic [7:0] code);
		logic [5:0]                            g;
		logic [39:0]                           bits;
		logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] c;
		if (code >= 8'(FIRST_CODE) && code <= 8'(LAST_CODE)) begin
			g = 6'(code - 8'(FIRST_CODE));
		end else begin
			g = '0;
		end
		bits = FONT_ROM[g];
		for (int i = 0; i < GLYPH_COLS; i++) begin
			c[i] = bits[38 - 8 * i -: GLYPH_ROWS];
		end
		return c;
	endfunction

	// rows of a page that lie on the screen
	function automatic logic [7:0] page_row_mask(logic [PG_W-1:0] pg);
		logic [7:0] m;
		for (int b = 0; b < 8; b++) begin
			m[b] = (int'(pg) * 8 + b) < SCREEN_HEIGHT;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pfbd_cmd_if.sv =====
// pfbd_cmd_if: command channel of the framebuffer drawer, valid/ready with
// the command fields. No dependencies.
`default_nettype none

interface pfbd_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic signed [9:0] x_pos;
	logic signed [9:0] y_pos;
	logic              pixel_on;
	logic [7:0]        char_code;
	logic [9:0]        byte_address;

	modport source (
		output valid, mode, x_pos, y_pos, pixel_on, char_code, byte_address,
		input  ready
	);
	modport sink (
		input  valid, mode, x_pos, y_pos, pixel_on, char_code, byte_address,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/pfbd_rsp_if.sv =====
// pfbd_rsp_if: result channel of the framebuffer drawer, valid/ready with
// the read byte. No dependencies.
`default_nettype none

interface pfbd_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (
		output valid, read_data,
		input  ready
	);
	modport sink (
		input  valid, read_data,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/pfbd_ram.sv =====
// pfbd_ram: generic simple dual-port ram, one write and one registered read
// per cycle. No dependencies.
`default_nettype none

module pfbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

// ===== hdl/pfbd_front.sv =====
// pfbd_front: takes command items and turns them into work descriptors
// (font lookup, read range check). Depends on pfbd_pkg and pfbd_cmd_if.
`default_nettype none

module pfbd_front (
	pfbd_cmd_if.sink        cmd,
	input  logic            init_done,
	input  logic            q_full,
	output pfbd_pkg::q_wr_t q_wr
);
	import pfbd_pkg::*;

	cmd_t entry;

	always_comb begin
		entry           = '0;
		entry.x         = cmd.x_pos;
		entry.y         = cmd.y_pos;
		entry.rd_addr   = ADDR_W'(cmd.byte_address);
		entry.rd_ok     = {2'b00, cmd.byte_address} < 12'(FB_BYTES);
		unique case (cmd.mode)
			MODE_PIXEL: begin
				entry.op        = OP_DRAW;
				entry.span      = SPAN_PIXEL;
				entry.cols[0]   = {{(GLYPH_ROWS-1){1'b0}}, cmd.pixel_on};
				entry.last_step = STEPS_PIXEL;
			end
			MODE_CHAR: begin
				entry.op        = OP_DRAW;
				entry.span      = SPAN_GLYPH;
				entry.cols      = glyph_cols(cmd.char_code);
				entry.last_step = STEPS_GLYPH;
			end
			MODE_CLEAR: begin
				entry.op = OP_WIPE;
			end
			MODE_READ: begin
				entry.op = OP_READ;
			end
		endcase
	end

	assign cmd.ready  = init_done && !q_full;
	assign q_wr.push  = cmd.valid && cmd.ready;
	assign q_wr.entry = entry;
endmodule

`default_nettype wire

// ===== hdl/pfbd_queue.sv =====
// pfbd_queue: short fifo of work descriptors between the front and the back.
// Depends on pfbd_pkg.
`default_nettype none

module pfbd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  pfbd_pkg::q_wr_t wr,
	input  logic            pop,
	output logic            full,
	output pfbd_pkg::q_rd_t rd
);
	import pfbd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && (count_q != '0);
	assign rd.valid = count_q != '0;
	assign rd.entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

`default_nettype wire

// ===== hdl/pfbd_back.sv =====
// pfbd_back: runs work descriptors against the frame store (read-modify-write
// per page byte, clear sweeps, reads) and holds the result register.
// Depends on pfbd_pkg, pfbd_rsp_if and pfbd_ram.
`default_nettype none

module pfbd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  pfbd_pkg::q_rd_t q_rd,
	output logic            q_pop,
	output logic            init_done,
	pfbd_rsp_if.source      rsp
);
	import pfbd_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FB_BYTES - 1);

	st_t               state_q;
	st_t               state_d;
	cmd_t              cur_q;
	logic [3:0]        step_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [7:0]        res_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        mask_s1;
	logic [7:0]        data_s1;

	logic [2:0]            col;
	logic                  half;
	logic [GLYPH_ROWS-1:0] col_bits;
	logic [10:0]           xc;
	logic                  x_ok;
	logic [7:0]            pg;
	logic                  pg_ok;
	logic [PG_W-1:0]       pg_u;
	logic [IDX_W-1:0]      idx;
	logic                  idx_ok;
	logic [15:0]           sh_m;
	logic [15:0]           sh_d;
	logic [7:0]            acc_mask;
	logic [7:0]            acc_data;
	logic                  acc_ok;

	logic              sweep_run;
	logic              load_out;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	// one page byte of one glyph column per step
	always_comb begin
		col      = step_q[3:1];
		half     = step_q[0];
		col_bits = cur_q.cols[col];
		xc       = {cur_q.x[9], cur_q.x} + {8'b0, col};
		x_ok     = !xc[10] && (xc[9:0] < 10'(SCREEN_WIDTH));
		pg       = {cur_q.y[9], cur_q.y[9:3]} + {7'b0, half};
		pg_ok    = !pg[7] && (pg[6:0] < 7'(PAGES));
		pg_u     = PG_W'(pg[6:0]);
		idx      = IDX_W'(pg_u) * IDX_W'(SCREEN_WIDTH) + IDX_W'(xc[9:0]);
		idx_ok   = {1'b0, idx} < (IDX_W + 1)'(FB_BYTES);
		sh_m     = 16'(cur_q.span) << cur_q.y[2:0];
		sh_d     = 16'(col_bits) << cur_q.y[2:0];
		acc_mask = (half ? sh_m[15:8] : sh_m[7:0]) & page_row_mask(pg_u);
		acc_data = half ? sh_d[15:8] : sh_d[7:0];
		acc_ok   = x_ok && pg_ok && idx_ok && (acc_mask != '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sweep_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_rd.valid) begin
					unique case (q_rd.entry.op)
						OP_DRAW: state_d = ST_DRAW;
						OP_WIPE: state_d = ST_WIPE;
						OP_READ: state_d = ST_READ;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DRAW: begin
				if (step_q == cur_q.last_step) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_RESULT;
			ST_WIPE: begin
				if (sweep_q == LAST_ADDR) begin
					state_d = ST_RESULT;
				end
			end
			ST_READ:  state_d = ST_RWAIT;
			ST_RWAIT: state_d = ST_RESULT;
			ST_RESULT: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		q_pop     = (state_q == ST_IDLE) && q_rd.valid;
		sweep_run = (state_q == ST_INIT) || (state_q == ST_WIPE);
		load_out  = (state_q == ST_RESULT) && (!out_valid_q || rsp.ready);
		ram_we    = sweep_run || valid_s1;
		ram_waddr = sweep_run ? sweep_q : addr_s1;
		ram_wdata = sweep_run ? 8'h00 : ((ram_rdata & ~mask_s1) | (data_s1 & mask_s1));
		ram_raddr = (state_q == ST_READ) ? cur_q.rd_addr : ADDR_W'(idx);
		init_done = state_q != ST_INIT;
	end

	pfbd_ram #(
		.WIDTH (8),
		.DEPTH (FB_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rd.entry;
		end
		addr_s1 <= ADDR_W'(idx);
		mask_s1 <= acc_mask;
		data_s1 <= acc_data;
		if (load_out) begin
			out_data_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			step_q      <= '0;
			sweep_q     <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_DRAW) && acc_ok;
			if (sweep_run) begin
				sweep_q <= (sweep_q == LAST_ADDR) ? '0 : sweep_q + 1'b1;
			end
			if (q_pop) begin
				step_q <= '0;
			end else if (state_q == ST_DRAW) begin
				step_q <= step_q + 1'b1;
			end
			if (q_pop) begin
				res_q <= '0;
			end else if (state_q == ST_RWAIT) begin
				res_q <= cur_q.rd_ok ? ram_rdata : 8'h00;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;

`ifndef SYNTHESIS
	a_s1_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_DRAW || state_q == ST_DRAIN))
		else $error("store write pending outside a draw");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE && q_rd.valid))
		else $error("queue popped while busy");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> (step_q <= cur_q.last_step))
		else $error("draw step past end");
	a_sweep_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (sweep_q == '0))
		else $error("sweep counter not rewound");
`endif
endmodule

`default_nettype wire

// ===== hdl/paged_framebuffer_pixel_char_drawer.sv =====
// paged_framebuffer_pixel_char_drawer: top level, front decoder, descriptor
// queue and store engine. Depends on pfbd_pkg, pfbd_cmd_if, pfbd_rsp_if,
// pfbd_front, pfbd_queue and pfbd_back.
//
//  channel  dir  fields
//  cmd      in   mode, x_pos, y_pos, pixel_on, char_code, byte_address
//  rsp      out  read_data (one item per command)
//
// draw char does ten page-byte read-modify-writes through the one store
// read port, and clear sweeps all FB_BYTES bytes of the store.
// after reset a pass clears all FB_BYTES (1024) bytes; cmd.ready is
// low until it ends. up to two commands queue while the engine works, and
// the engine waits in place while a result sits untaken on rsp.
`default_nettype none

module paged_framebuffer_pixel_char_drawer (
	input  logic       clk,
	input  logic       arst_n,
	pfbd_cmd_if.sink   cmd,
	pfbd_rsp_if.source rsp
);
	import pfbd_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;
	logic  init_done;

	pfbd_front u_front (
		.cmd       (cmd),
		.init_done (init_done),
		.q_full    (q_full),
		.q_wr      (q_wr)
	);

	pfbd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.rd     (q_rd)
	);

	pfbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rd      (q_rd),
		.q_pop     (q_pop),
		.init_done (init_done),
		.rsp       (rsp)
	);
endmodule

`default_nettype wire

// ===== tb/paged_framebuffer_pixel_char_drawer_tb.sv =====
// paged_framebuffer_pixel_char_drawer_tb: self-checking bench for the paged framebuffer
// drawer; a shadow framebuffer and font predict the byte of every command's result.
// Depends on pfbd_pkg, pfbd_cmd_if, pfbd_rsp_if and paged_framebuffer_pixel_char_drawer.
`default_nettype none

module paged_framebuffer_pixel_char_drawer_tb;
	import pfbd_pkg::*;

	localparam int QUIET_LIMIT   = 8192;
	localparam int PHASE_ITEMS   = 481;
	localparam int SETTLE_CYCLES = 64;
	localparam int MAX_REPORTS   = 40;
	localparam int PHASES        = 4;

	localparam int unsigned SEND_IDLE_PLAN  [PHASES] = '{0, 87, 0, 23};
	localparam int unsigned RECV_STALL_PLAN [PHASES] = '{0, 0, 87, 23};

	// column bytes, bit r is glyph row r
	localparam logic [7:0] GLYPH_FONT [GLYPHS][GLYPH_COLS] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00},
		'{8'h00, 8'h07, 8'h00, 8'h07, 8'h00}, '{8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14},
		'{8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12}, '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62},
		'{8'h36, 8'h49, 8'h55, 8'h22, 8'h50}, '{8'h00, 8'h05, 8'h03, 8'h00, 8'h00},
		'{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00}, '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00},
		'{8'h14, 8'h08, 8'h3E, 8'h08, 8'h14}, '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08},
		'{8'h00, 8'h50, 8'h30, 8'h00, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
		'{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
		'{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
		'{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
		'{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
		'{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
		'{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
		'{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h00, 8'h56, 8'h36, 8'h00, 8'h00},
		'{8'h08, 8'h14, 8'h22, 8'h41, 8'h00}, '{8'h14, 8'h14, 8'h14, 8'h14, 8'h14},
		'{8'h00, 8'h41, 8'h22, 8'h14, 8'h08}, '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06},
		'{8'h32, 8'h49, 8'h79, 8'h41, 8'h3E}, '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},
		'{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
		'{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
		'{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01}, '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},
		'{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}, '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
		'{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01}, '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
		'{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
		'{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
		'{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}, '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
		'{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46}, '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},
		'{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}, '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
		'{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F}, '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
		'{8'h63, 8'h14, 8'h08, 8'h14, 8'h63}, '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07},
		'{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
	};

	typedef struct {
		logic [1:0]        mode;
		logic signed [9:0] x_pos;
		logic signed [9:0] y_pos;
		logic              pixel_on;
		logic [7:0]        char_code;
		logic [9:0]        byte_address;
	} draw_cmd_t;

	logic clk;
	logic arst_n;

	pfbd_cmd_if cmd_ch ();
	pfbd_rsp_if rsp_ch ();

	paged_framebuffer_pixel_char_drawer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	draw_cmd_t   pending_cmds [$];
	draw_cmd_t   in_flight;
	logic [7:0]  expected_bytes [$];
	logic [7:0]  shadow_fb [FB_BYTES];
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	int          mismatches;
	int          results_seen;
	int          quiet_cycles;
	int          last_x;
	int          last_y;

	function automatic int clamp(int v, int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	function automatic void plot(int x, int y, logic on);
		int idx;
		if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT) begin
			idx = SCREEN_WIDTH * (y / 8) + x;
			shadow_fb[idx][y % 8] = on;
		end
	endfunction

	// updates the shadow framebuffer and returns the byte the block must answer with
	function automatic logic [7:0] apply_command(draw_cmd_t c);
		int         g;
		logic [7:0] data;
		data = '0;
		case (c.mode)
			MODE_PIXEL: begin
				plot(int'(c.x_pos), int'(c.y_pos), c.pixel_on);
			end
			MODE_CHAR: begin
				g = (c.char_code >= FIRST_CODE && c.char_code <= LAST_CODE) ?
					int'(c.char_code) - FIRST_CODE : 0;
				for (int col = 0; col < GLYPH_COLS; col++) begin
					for (int row = 0; row < GLYPH_ROWS; row++) begin
						plot(int'(c.x_pos) + col, int'(c.y_pos) + row, GLYPH_FONT[g][col][row]);
					end
				end
			end
			MODE_CLEAR: begin
				foreach (shadow_fb[i]) shadow_fb[i] = '0;
			end
			MODE_READ: begin
				if (c.byte_address < FB_BYTES) data = shadow_fb[c.byte_address];
			end
		endcase
		return data;
	endfunction

	task automatic push_cmd(logic [1:0] mode, int x, int y, logic on, int code, int addr);
		draw_cmd_t c;
		c.mode         = mode;
		c.x_pos        = 10'(x);
		c.y_pos        = 10'(y);
		c.pixel_on     = on;
		c.char_code    = 8'(code);
		c.byte_address = 10'(addr);
		pending_cmds.push_back(c);
	endtask

	// draws mostly land near the screen; reads mostly look at what was just drawn
	function automatic draw_cmd_t random_cmd();
		draw_cmd_t   c;
		int unsigned pick;
		int          px;
		int          py;
		c.mode         = MODE_READ;
		c.x_pos        = 10'($urandom);
		c.y_pos        = 10'($urandom);
		c.pixel_on     = 1'($urandom);
		c.char_code    = 8'($urandom);
		c.byte_address = 10'($urandom);
		pick = $urandom_range(999);
		if (pick < 6) begin
			c.mode = MODE_CLEAR;
		end else if (pick < 560) begin
			c.mode = (pick < 300) ? MODE_PIXEL : MODE_CHAR;
			if ($urandom_range(9) != 0) begin
				px = int'($urandom_range(139)) - 6;
				py = int'($urandom_range(79)) - 8;
				c.x_pos = 10'(px);
				c.y_pos = 10'(py);
			end
			if (c.mode == MODE_CHAR && $urandom_range(9) < 8) begin
				c.char_code = 8'($urandom_range(LAST_CODE, FIRST_CODE));
			end
			last_x = clamp(int'(c.x_pos), SCREEN_WIDTH - 1);
			last_y = clamp(int'(c.y_pos), SCREEN_HEIGHT - 1);
		end else if ($urandom_range(9) < 7) begin
			px = clamp(last_x + int'($urandom_range(4)), SCREEN_WIDTH - 1);
			py = clamp(last_y + int'($urandom_range(6)), SCREEN_HEIGHT - 1);
			c.byte_address = 10'(SCREEN_WIDTH * (py / 8) + px);
		end
		return c;
	endfunction

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_bytes.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic report_mismatch(string what);
		if (mismatches < MAX_REPORTS) $display("mismatch: %s", what);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : cmd_driver
		logic take_next;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_bytes.push_back(apply_command(in_flight));
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				take_next = pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct;
				if (take_next) begin
					in_flight = pending_cmds.pop_front();
					cmd_ch.mode         <= in_flight.mode;
					cmd_ch.x_pos        <= in_flight.x_pos;
					cmd_ch.y_pos        <= in_flight.y_pos;
					cmd_ch.pixel_on     <= in_flight.pixel_on;
					cmd_ch.char_code    <= in_flight.char_code;
					cmd_ch.byte_address <= in_flight.byte_address;
				end
				cmd_ch.valid <= take_next;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		logic [7:0] want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("result %0d with no command outstanding, read_data %02h",
						results_seen, rsp_ch.read_data));
				end else begin
					want = expected_bytes.pop_front();
					if (rsp_ch.read_data !== want) begin
						report_mismatch($sformatf("result %0d read_data %02h, expected %02h",
							results_seen, rsp_ch.read_data, want));
					end
				end
				results_seen++;
			end
			rsp_ch.ready <= $urandom_range(99) >= receiver_stall_pct;
		end
	end

	// covers the clearing pass after reset and a clear command behind a stalled result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.mode         = MODE_PIXEL;
		cmd_ch.x_pos        = '0;
		cmd_ch.y_pos        = '0;
		cmd_ch.pixel_on     = 1'b0;
		cmd_ch.char_code    = '0;
		cmd_ch.byte_address = '0;
		rsp_ch.ready        = 1'b0;
		sender_idle_pct     = 0;
		receiver_stall_pct  = 0;
		mismatches          = 0;
		results_seen        = 0;
		quiet_cycles        = 0;
		last_x              = 0;
		last_y              = 0;
		foreach (shadow_fb[i]) shadow_fb[i] = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		push_cmd(MODE_READ,     0,    0, 1'b0,   0,    0);
		push_cmd(MODE_PIXEL,    0,    0, 1'b1,   0,    0);
		push_cmd(MODE_PIXEL,  127,   63, 1'b1,   0,    0);
		push_cmd(MODE_PIXEL,   -1,    0, 1'b1,   0,    0);
		push_cmd(MODE_PIXEL,  128,    5, 1'b1,   0,    0);
		push_cmd(MODE_PIXEL,    3,   64, 1'b1,   0,    0);
		push_cmd(MODE_PIXEL, -512, -512, 1'b1,   0,    0);
		push_cmd(MODE_PIXEL,  511,  511, 1'b1, 255, 1023);
		push_cmd(MODE_READ,     0,    0, 1'b0,   0,    0);
		push_cmd(MODE_READ,     0,    0, 1'b0,   0, 1023);
		push_cmd(MODE_CHAR,    10,    9, 1'b0,  65,    0);
		push_cmd(MODE_READ,     0,    0, 1'b0,   0,  138);
		push_cmd(MODE_READ,     0,    0, 1'b0,   0,  266);
		push_cmd(MODE_CHAR,     0,    0, 1'b0,  90,    0);
		push_cmd(MODE_READ,     0,    0, 1'b0,   0,    0);
		push_cmd(MODE_CHAR,   124,   58, 1'b0,  48,    0);
		push_cmd(MODE_READ,     0,    0, 1'b0,   0, 1020);
		push_cmd(MODE_CHAR,   122,   58, 1'b1, 255,    0);
		push_cmd(MODE_READ,     0,    0, 1'b0,   0, 1020);
		push_cmd(MODE_CHAR,    -2,   -3, 1'b1,   0,    0);
		push_cmd(MODE_CHAR,    10,    9, 1'b0,  91,    0);
		push_cmd(MODE_READ,     0,    0, 1'b0,   0,  138);
		push_cmd(MODE_PIXEL,    0,    0, 1'b0, 255, 1023);
		push_cmd(MODE_READ,  -512,  511, 1'b1, 255,    0);
		push_cmd(MODE_CLEAR,    5,    5, 1'b1,  65,    7);
		push_cmd(MODE_READ,     0,    0, 1'b0,   0, 1023);
		wait_idle();

		// the sender holds off until every result is back at each phase boundary
		for (int p = 0; p < PHASES; p++) begin
			sender_idle_pct    = SEND_IDLE_PLAN[p];
			receiver_stall_pct = RECV_STALL_PLAN[p];
			repeat (PHASE_ITEMS) pending_cmds.push_back(random_cmd());
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
